// ----- src/dsd_pkg.sv -----
package dsd_pkg;

	localparam logic [13:0] MIN_YEAR  = 14'd1582;
	localparam logic [13:0] QUAD_CENT = 14'd400;
	localparam logic [8:0]  R400_LAST = 9'd399;
	localparam logic [3:0]  DEC_MONTH = 4'd12;

	typedef logic [2:0] upc_t;

	// microcode addresses
	localparam upc_t A_IDLE   = 3'd0;
	localparam upc_t A_REDUCE = 3'd1;
	localparam upc_t A_CHECK  = 3'd2;
	localparam upc_t A_BORROW = 3'd3;
	localparam upc_t A_EMIT   = 3'd4;

	typedef enum logic [2:0] {
		OP_NOP    = 3'd0,
		OP_LOAD   = 3'd1,
		OP_REDUCE = 3'd2,
		OP_CHECK  = 3'd3,
		OP_BORROW = 3'd4,
		OP_EMIT   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS  = 3'd0,
		C_NOSTART = 3'd1,
		C_GE400   = 3'd2,
		C_INVALID = 3'd3,
		C_DAYLE0  = 3'd4
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
	} ctl_t;

	typedef struct packed {
		logic ge400;
		logic invalid;
		logic day_le0;
	} stat_t;

	// r is year mod 400, ylo the two low bits of the year
	function automatic logic is_leap(input logic [1:0] ylo, input logic [8:0] r);
		logic cent;
		cent = (r == 9'd0) || (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
		return ((ylo == 2'd0) && !cent) || (r == 9'd0);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = lp ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- src/dsd_useq.sv -----
module dsd_useq
	import dsd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output ctl_t  ctl,
	output logic  busy
);

	upc_t upc_q;
	logic take;

	// control store
	always_comb begin
		case (upc_q)
			A_IDLE:   ctl = '{op: OP_LOAD,   cond: C_NOSTART, target: A_IDLE};
			A_REDUCE: ctl = '{op: OP_REDUCE, cond: C_GE400,   target: A_REDUCE};
			A_CHECK:  ctl = '{op: OP_CHECK,  cond: C_INVALID, target: A_IDLE};
			A_BORROW: ctl = '{op: OP_BORROW, cond: C_DAYLE0,  target: A_BORROW};
			A_EMIT:   ctl = '{op: OP_EMIT,   cond: C_ALWAYS,  target: A_IDLE};
			default:  ctl = '{op: OP_NOP,    cond: C_ALWAYS,  target: A_IDLE};
		endcase
	end

	always_comb begin
		case (ctl.cond)
			C_ALWAYS:  take = 1'b1;
			C_NOSTART: take = !start;
			C_GE400:   take = stat.ge400;
			C_INVALID: take = stat.invalid;
			C_DAYLE0:  take = stat.day_le0;
			default:   take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= A_IDLE;
		end else begin
			upc_q <= take ? ctl.target : upc_q + 3'd1;
		end
	end

	assign busy = (upc_q != A_IDLE);

endmodule

// ----- src/dsd_dp.sv -----
module dsd_dp
	import dsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  logic [4:0]  day_in,
	input  logic [3:0]  month_in,
	input  logic [13:0] year_in,
	input  logic [15:0] days_to_subtract,
	output stat_t       stat,
	output logic        done,
	output logic        date_valid,
	output logic [4:0]  day_out,
	output logic [3:0]  month_out,
	output logic [13:0] year_out
);

	logic [4:0]         d_q;
	logic [15:0]        n_q;
	logic [3:0]         mon_q;
	logic [13:0]        yr_q;
	logic [13:0]        r400_q;   // year mod 400 once reduced
	logic signed [16:0] day_q;

	logic        done_q;
	logic        valid_q;
	logic [4:0]  day_out_q;
	logic [3:0]  month_out_q;
	logic [13:0] year_out_q;

	logic       cur_leap;
	logic [4:0] cur_len;
	logic       wrap;
	logic [3:0] prev_mon;
	logic [13:0] prev_yr;
	logic [8:0] prev_r;
	logic [4:0] prev_len;

	assign cur_leap = is_leap(yr_q[1:0], r400_q[8:0]);
	assign cur_len  = month_len(mon_q, cur_leap);

	// previous month, with year borrow below January
	assign wrap     = (mon_q <= 4'd1);
	assign prev_mon = wrap ? DEC_MONTH : mon_q - 4'd1;
	assign prev_yr  = wrap ? yr_q - 14'd1 : yr_q;
	assign prev_r   = !wrap ? r400_q[8:0] :
	                  (r400_q[8:0] == 9'd0) ? R400_LAST : r400_q[8:0] - 9'd1;
	assign prev_len = month_len(prev_mon, is_leap(prev_yr[1:0], prev_r));

	assign stat.ge400   = (r400_q >= QUAD_CENT);
	assign stat.invalid = (yr_q < MIN_YEAR) || (mon_q == 4'd0) || (mon_q > DEC_MONTH) ||
	                      (d_q == 5'd0) || (d_q > cur_len);
	assign stat.day_le0 = (day_q < 17'sd1);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				d_q    <= day_in;
				n_q    <= days_to_subtract;
				mon_q  <= month_in;
				yr_q   <= year_in;
				r400_q <= year_in;
			end
			OP_REDUCE: begin
				if (stat.ge400) begin
					r400_q <= r400_q - QUAD_CENT;
				end
			end
			OP_CHECK: begin
				day_q <= $signed({12'b0, d_q}) - $signed({1'b0, n_q});
			end
			OP_BORROW: begin
				if (stat.day_le0) begin
					mon_q  <= prev_mon;
					yr_q   <= prev_yr;
					r400_q <= {5'b0, prev_r};
					day_q  <= day_q + $signed({12'b0, prev_len});
				end
			end
			default: begin
			end
		endcase
	end

	// result word registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((ctl.op == OP_CHECK) && stat.invalid) || (ctl.op == OP_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_CHECK && stat.invalid) begin
			valid_q     <= 1'b0;
			day_out_q   <= '0;
			month_out_q <= '0;
			year_out_q  <= '0;
		end else if (ctl.op == OP_EMIT) begin
			valid_q     <= 1'b1;
			day_out_q   <= day_q[4:0];
			month_out_q <= mon_q;
			year_out_q  <= yr_q;
		end
	end

	assign done       = done_q;
	assign date_valid = valid_q;
	assign day_out    = day_out_q;
	assign month_out  = month_out_q;
	assign year_out   = year_out_q;

endmodule

// ----- src/date_subtract_days.sv -----
// From accept to done, the microcode loads the word, reduces the year mod 400 step by step,
// checks the date, borrows one month per step until the day is positive, then emits the
// result; an invalid date is reported from the check step, with no month borrows.
// One word at a time: the microcode loop takes one month borrow per cycle and busy stays
// high until the result word is issued; the next word can be taken at the edge that takes
// the result. done marks each result for exactly one cycle; the receiver cannot stall.
module date_subtract_days
	import dsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  day_in,
	input  logic [3:0]  month_in,
	input  logic [13:0] year_in,
	input  logic [15:0] days_to_subtract,
	output logic        done,
	output logic        date_valid,
	output logic [4:0]  day_out,
	output logic [3:0]  month_out,
	output logic [13:0] year_out
);

	ctl_t  ctl;
	stat_t stat;

	dsd_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	dsd_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.day_in           (day_in),
		.month_in         (month_in),
		.year_in          (year_in),
		.days_to_subtract (days_to_subtract),
		.stat             (stat),
		.done             (done),
		.date_valid       (date_valid),
		.day_out          (day_out),
		.month_out        (month_out),
		.year_out         (year_out)
	);

endmodule
